[hdl/bna_pkg.sv]
package bna_pkg;

  // Tone timer input clock in hertz.
  localparam logic [21:0] TONE_CLOCK = 22'd4000000;

  // Reset values of the tone limits.
  localparam logic [15:0] MIN_TONE_RESET = 16'd100;
  localparam logic [15:0] MAX_TONE_RESET = 16'd20000;

  // Configuration register indexes.
  localparam logic CFG_MIN_TONE = 1'b0;
  localparam logic CFG_MAX_TONE = 1'b1;

  // Item opcodes.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] now_time;
    logic [15:0] tick_ms;
    logic [15:0] note_freq;
    logic [15:0] note_duration;
    logic [15:0] note_swap_time;
  } in_t;

  typedef struct packed {
    logic        tone_on;
    logic [21:0] tone_period;
    logic [20:0] tone_compare;
    logic        reload;
    logic        dropped;
  } out_t;

  // One entry of the note table.
  typedef struct packed {
    logic [15:0] hz;
    logic [15:0] swap_ms;
    logic [31:0] end_ms;
  } note_t;

  // Status of the period divider.
  typedef struct packed {
    logic        busy;
    logic [21:0] quotient;
  } div_result_t;

endpackage

[hdl/bna_ram.sv]
module bna_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/bna_div.sv]
module bna_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [15:0]          divisor,
  output bna_pkg::div_result_t status
);

  logic [15:0] div_r;
  logic [15:0] rem_r;
  logic [21:0] quo_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic [16:0] trial;
  logic [15:0] diff;
  logic        fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem_r, bna_pkg::TONE_CLOCK[cnt_r]};
    fits  = (trial >= {1'b0, div_r});
    diff  = trial[15:0] - div_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'd21;
    end else if (busy_r) begin
      if (cnt_r == 5'd0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 5'd1;
      end
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= divisor;
      rem_r <= 16'd0;
      quo_r <= 22'd0;
    end else if (busy_r) begin
      rem_r <= fits ? diff : trial[15:0];
      quo_r <= {quo_r[20:0], fits};
    end
  end

  assign status.busy     = busy_r;
  assign status.quotient = quo_r;

endmodule

[hdl/buzzer_note_arpeggiator_unit.sv]
// Sequencing: an add transaction or a tick with an empty table goes straight to S_DONE;
// a tick passes S_CHK, then S_MRD/S_MWR per entry moved when an expired note is removed,
// then S_DIVW. A new audible frequency runs the bit-per-cycle period divider alongside
// compaction, and S_DIVW waits for it to finish. S_DONE waits for a free result register.
// Throughput: one transaction at a time; a new one is taken only back in S_IDLE.
// Reset: synchronous, active low; clears count, play and tone state, limits 100/20000 Hz.
module buzzer_note_arpeggiator_unit #(
  parameter int NOTE_SLOTS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bna_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output bna_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_data
);

  localparam int IDX_W = (NOTE_SLOTS > 1) ? $clog2(NOTE_SLOTS) : 1;
  localparam int CNT_W = $clog2(NOTE_SLOTS + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CHK  = 6'b000010,
    S_MRD  = 6'b000100,
    S_MWR  = 6'b001000,
    S_DIVW = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0]      min_hz_r, max_hz_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] play_idx_r, play_idx_nxt;
  logic [31:0]      elapsed_r, elapsed_nxt;
  logic [15:0]      last_hz_r, last_hz_nxt;
  logic             stopped_r, stopped_nxt;
  logic [21:0]      held_r, held_nxt;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] k_plus;
  logic [31:0]      now_r, now_nxt;
  logic [15:0]      tick_r, tick_nxt;
  logic             reload_r, reload_nxt;
  logic             drop_r, drop_nxt;
  logic             out_valid_r, out_valid_nxt;
  bna_pkg::out_t    out_data_r, out_data_nxt;

  logic               accept;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  bna_pkg::note_t     ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  bna_pkg::note_t     ram_rdata;
  logic               div_start;
  bna_pkg::div_result_t div_st;
  logic [CNT_W-1:0]   idx_use;
  logic [32:0]        el_sum;
  logic [31:0]        el_new;
  logic               audible;

  bna_ram #(
    .WIDTH ($bits(bna_pkg::note_t)),
    .DEPTH (NOTE_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bna_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (ram_rdata.hz),
    .status  (div_st)
  );

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign k_plus    = k_r + CNT_W'(1);

  // Wrap the play index when it ran past the end of the table.
  assign idx_use = (play_idx_r >= count_r) ? '0 : play_idx_r;

  // Saturating play time and audible range of the current entry.
  always_comb begin
    el_sum  = {1'b0, elapsed_r} + {17'd0, tick_r};
    el_new  = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];
    audible = (ram_rdata.hz != 16'd0) && (ram_rdata.hz >= min_hz_r) &&
              (ram_rdata.hz <= max_hz_r);
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    play_idx_nxt  = play_idx_r;
    elapsed_nxt   = elapsed_r;
    last_hz_nxt   = last_hz_r;
    stopped_nxt   = stopped_r;
    held_nxt      = held_r;
    pend_nxt      = pend_r;
    k_nxt         = k_r;
    now_nxt       = now_r;
    tick_nxt      = tick_r;
    reload_nxt    = reload_r;
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[IDX_W-1:0];
    ram_wdata.hz      = in_data.note_freq;
    ram_wdata.swap_ms = in_data.note_swap_time;
    ram_wdata.end_ms  = in_data.now_time + {16'd0, in_data.note_duration};
    ram_raddr     = idx_use[IDX_W-1:0];
    div_start     = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          now_nxt    = in_data.now_time;
          tick_nxt   = in_data.tick_ms;
          reload_nxt = 1'b0;
          drop_nxt   = 1'b0;
          pend_nxt   = 1'b0;
          state_nxt  = S_DONE;
          if (in_data.opcode == bna_pkg::OP_ADD) begin
            if (count_r == CNT_W'(NOTE_SLOTS)) begin
              drop_nxt = 1'b1;
            end else begin
              ram_we    = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end
          end else if (count_r == '0) begin
            if (last_hz_r != 16'd0) begin
              last_hz_nxt = 16'd0;
              stopped_nxt = 1'b1;
            end
          end else begin
            if (play_idx_r >= count_r) begin
              elapsed_nxt = 32'd0;
            end
            play_idx_nxt = idx_use;
            state_nxt    = S_CHK;
          end
        end
      end
      S_CHK: begin
        // Entry under the play index is on the read port now.
        if (ram_rdata.hz != last_hz_r) begin
          last_hz_nxt = ram_rdata.hz;
          stopped_nxt = !audible;
          if (audible) begin
            div_start  = 1'b1;
            pend_nxt   = 1'b1;
            reload_nxt = 1'b1;
          end
        end
        if (ram_rdata.end_ms < now_r) begin
          elapsed_nxt = el_new;
          k_nxt       = play_idx_r;
          state_nxt   = S_MRD;
        end else if (el_new > {16'd0, ram_rdata.swap_ms}) begin
          play_idx_nxt = play_idx_r + CNT_W'(1);
          elapsed_nxt  = 32'd0;
          state_nxt    = S_DIVW;
        end else begin
          elapsed_nxt = el_new;
          state_nxt   = S_DIVW;
        end
      end
      S_MRD: begin
        // Compaction: fetch the next entry or finish the removal.
        if (k_plus < count_r) begin
          ram_raddr = k_plus[IDX_W-1:0];
          state_nxt = S_MWR;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_DIVW;
        end
      end
      S_MWR: begin
        ram_we    = 1'b1;
        ram_waddr = k_r[IDX_W-1:0];
        ram_wdata = ram_rdata;
        k_nxt     = k_plus;
        state_nxt = S_MRD;
      end
      S_DIVW: begin
        if (!div_st.busy) begin
          if (pend_r) begin
            held_nxt = div_st.quotient;
            pend_nxt = 1'b0;
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Result register frees up when empty or being taken this cycle.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.tone_on      = !stopped_r;
          out_data_nxt.tone_period  = held_r;
          out_data_nxt.tone_compare = held_r[21:1];
          out_data_nxt.reload       = reload_r;
          out_data_nxt.dropped      = drop_r;
          state_nxt                 = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and tone state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      play_idx_r  <= '0;
      elapsed_r   <= 32'd0;
      last_hz_r   <= 16'd0;
      stopped_r   <= 1'b1;
      held_r      <= 22'd0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      play_idx_r  <= play_idx_nxt;
      elapsed_r   <= elapsed_nxt;
      last_hz_r   <= last_hz_nxt;
      stopped_r   <= stopped_nxt;
      held_r      <= held_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    now_r      <= now_nxt;
    tick_r     <= tick_nxt;
    reload_r   <= reload_nxt;
    drop_r     <= drop_nxt;
    out_data_r <= out_data_nxt;
  end

  // Tone limit registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_hz_r <= bna_pkg::MIN_TONE_RESET;
      max_hz_r <= bna_pkg::MAX_TONE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bna_pkg::CFG_MIN_TONE: min_hz_r <= cfg_data;
        bna_pkg::CFG_MAX_TONE: max_hz_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(NOTE_SLOTS))
    else $error("note count exceeds table size");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    play_idx_r <= count_r)
    else $error("play index beyond note count");

  a_div_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.busy |-> (state_r != S_IDLE) && (state_r != S_DONE))
    else $error("divider busy outside a tick");

  a_reload_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.reload |-> out_data_r.tone_on)
    else $error("reload reported with tone off");
`endif

endmodule
